### hw/rtl/azavg_pkg.sv
// shared constants, types and codes of the azimuthal average reconstruction block
`default_nettype none
package azavg_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;
  localparam int unsigned FRAC_BITS  = 4;

  localparam int unsigned NBINS_MAX = MAX_WIDTH / 2;
  localparam int unsigned BIN_AW    = $clog2(NBINS_MAX);
  localparam int unsigned COL_W     = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W     = $clog2(MAX_HEIGHT);

  localparam int unsigned DIM_W   = 11;
  localparam int unsigned CTR_W   = 14;
  localparam int unsigned PIX_W   = 16;
  localparam int unsigned SUM_W   = 36;
  localparam int unsigned CNT_W   = 21;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  localparam int unsigned POS_W    = (COL_W + FRAC_BITS > CTR_W) ? COL_W + FRAC_BITS : CTR_W;
  localparam int unsigned DIFF_W   = POS_W + 1;
  localparam int unsigned D2_W     = 2 * POS_W + 1;
  localparam int unsigned SQ_IN_W  = ((D2_W + 3) / 2) * 2;
  localparam int unsigned SQ_OUT_W = SQ_IN_W / 2;

  localparam int unsigned MAG_W     = SUM_W + 16;
  localparam int unsigned MEAN_W    = MAG_W + 1;
  localparam int unsigned DIV_STEPS = MAG_W;
  localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);
  localparam int unsigned WGT_W     = FRAC_BITS + 2;
  localparam int unsigned ACC_W     = MEAN_W + WGT_W;
  localparam int unsigned RND_SH    = FRAC_BITS + 16;

  typedef enum logic [1:0] {
    REG_WIDTH    = 2'd0,
    REG_HEIGHT   = 2'd1,
    REG_CENTER_X = 2'd2,
    REG_CENTER_Y = 2'd3
  } reg_idx_e;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_READ = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ADDR_LOAD = 2'd0,
    ADDR_LO   = 2'd1,
    ADDR_HI   = 2'd2
  } addr_sel_e;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_MUL_X, S_MUL_Y, S_SQ_INIT, S_SQRT, S_LD_RD, S_LD_WR,
    S_RD_LO, S_DV_LO_INIT, S_DV_LO, S_RD_HI, S_DV_HI_INIT, S_DV_HI,
    S_MIX_A, S_MIX_B, S_PUSH
  } state_e;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [CTR_W-1:0] center_x;
    logic [CTR_W-1:0] center_y;
  } cfg_t;

  typedef struct packed {
    logic              cap_pixel;
    logic              mul_x;
    logic              mul_y;
    logic              sq_init;
    logic              sq_quad;
    logic              sq_step;
    logic              mem_rd;
    addr_sel_e         addr_sel;
    logic              mem_acc;
    logic              mem_clr;
    logic [BIN_AW-1:0] clr_addr;
    logic              dv_init;
    logic              dv_step;
    logic              mean_lo_cap;
    logic              mix_a;
    logic              mix_b;
    logic              out_load;
    logic              advance;
  } dp_cmd_t;

  typedef struct packed {
    logic sq_last;
    logic load_hit;
    logic read_hit;
    logic img_end;
  } dp_sts_t;

endpackage
`default_nettype wire

### hw/rtl/azavg_regs.sv
// apb configuration registers
`default_nettype none
module azavg_regs (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [azavg_pkg::PADDR_W-1:0]     paddr,
  input  wire  [azavg_pkg::PDATA_W-1:0]     pwdata,
  output logic [azavg_pkg::PDATA_W-1:0]     prdata,
  output logic                              pready,
  output azavg_pkg::cfg_t                   cfg_o
);

  azavg_pkg::cfg_t     cfg_q, cfg_d;
  azavg_pkg::reg_idx_e idx;
  logic                wr_en;

  assign idx    = azavg_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        azavg_pkg::REG_WIDTH:    cfg_d.width    = pwdata[azavg_pkg::DIM_W-1:0];
        azavg_pkg::REG_HEIGHT:   cfg_d.height   = pwdata[azavg_pkg::DIM_W-1:0];
        azavg_pkg::REG_CENTER_X: cfg_d.center_x = pwdata[azavg_pkg::CTR_W-1:0];
        azavg_pkg::REG_CENTER_Y: cfg_d.center_y = pwdata[azavg_pkg::CTR_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      azavg_pkg::REG_WIDTH:    prdata = azavg_pkg::PDATA_W'(cfg_q.width);
      azavg_pkg::REG_HEIGHT:   prdata = azavg_pkg::PDATA_W'(cfg_q.height);
      azavg_pkg::REG_CENTER_X: prdata = azavg_pkg::PDATA_W'(cfg_q.center_x);
      azavg_pkg::REG_CENTER_Y: prdata = azavg_pkg::PDATA_W'(cfg_q.center_y);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width    <= azavg_pkg::DIM_W'(512);
      cfg_q.height   <= azavg_pkg::DIM_W'(512);
      cfg_q.center_x <= azavg_pkg::CTR_W'(4096);
      cfg_q.center_y <= azavg_pkg::CTR_W'(3688);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/azavg_ctrl.sv
// sequencing state machine of the radial profile block
`default_nettype none
module azavg_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  input  wire                  command_i,
  input  wire                  out_ready_i,
  input  azavg_pkg::dp_sts_t   sts_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  output azavg_pkg::dp_cmd_t   cmd_o
);

  azavg_pkg::state_e            state_q, state_d;
  logic                         phase_q, phase_d;
  logic [azavg_pkg::BIN_AW-1:0] clr_addr_q, clr_addr_d;
  logic [azavg_pkg::DCNT_W-1:0] dv_cnt_q, dv_cnt_d;
  logic                         out_valid_q, out_valid_d;
  logic                         accept, match, push_fire, dv_last;

  assign in_ready_o  = (state_q == azavg_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  // a load counts in the loading phase, a read in readout
  assign match       = ((command_i == azavg_pkg::CMD_READ) == phase_q);
  assign push_fire   = (state_q == azavg_pkg::S_PUSH) && (!out_valid_q || out_ready_i);
  assign dv_last     = (dv_cnt_q == azavg_pkg::DCNT_W'(azavg_pkg::DIV_STEPS - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      azavg_pkg::S_CLEAR: begin
        if (clr_addr_q == azavg_pkg::BIN_AW'(azavg_pkg::NBINS_MAX - 1)) state_d = azavg_pkg::S_IDLE;
      end
      azavg_pkg::S_IDLE: begin
        if (accept && match) state_d = azavg_pkg::S_MUL_X;
      end
      azavg_pkg::S_MUL_X:   state_d = azavg_pkg::S_MUL_Y;
      azavg_pkg::S_MUL_Y:   state_d = azavg_pkg::S_SQ_INIT;
      azavg_pkg::S_SQ_INIT: state_d = azavg_pkg::S_SQRT;
      azavg_pkg::S_SQRT: begin
        if (sts_i.sq_last) state_d = phase_q ? azavg_pkg::S_RD_LO : azavg_pkg::S_LD_RD;
      end
      azavg_pkg::S_LD_RD: state_d = sts_i.load_hit ? azavg_pkg::S_LD_WR : azavg_pkg::S_IDLE;
      azavg_pkg::S_LD_WR: state_d = azavg_pkg::S_IDLE;
      azavg_pkg::S_RD_LO: state_d = sts_i.read_hit ? azavg_pkg::S_DV_LO_INIT : azavg_pkg::S_PUSH;
      azavg_pkg::S_DV_LO_INIT: state_d = azavg_pkg::S_DV_LO;
      azavg_pkg::S_DV_LO: begin
        if (dv_last) state_d = azavg_pkg::S_RD_HI;
      end
      azavg_pkg::S_RD_HI:      state_d = azavg_pkg::S_DV_HI_INIT;
      azavg_pkg::S_DV_HI_INIT: state_d = azavg_pkg::S_DV_HI;
      azavg_pkg::S_DV_HI: begin
        if (dv_last) state_d = azavg_pkg::S_MIX_A;
      end
      azavg_pkg::S_MIX_A: state_d = azavg_pkg::S_MIX_B;
      azavg_pkg::S_MIX_B: state_d = azavg_pkg::S_PUSH;
      azavg_pkg::S_PUSH: begin
        if (push_fire) state_d = sts_i.img_end ? azavg_pkg::S_CLEAR : azavg_pkg::S_IDLE;
      end
      default: state_d = azavg_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.sq_quad = !phase_q;
    cmd_o.clr_addr = clr_addr_q;
    phase_d       = phase_q;
    clr_addr_d    = clr_addr_q;
    dv_cnt_d      = dv_cnt_q;
    out_valid_d   = (out_valid_q && !out_ready_i) || push_fire;
    unique case (state_q)
      azavg_pkg::S_CLEAR: begin
        cmd_o.mem_clr = 1'b1;
        clr_addr_d    = clr_addr_q + 1'b1;
      end
      azavg_pkg::S_IDLE:    cmd_o.cap_pixel = accept;
      azavg_pkg::S_MUL_X:   cmd_o.mul_x     = 1'b1;
      azavg_pkg::S_MUL_Y:   cmd_o.mul_y     = 1'b1;
      azavg_pkg::S_SQ_INIT: cmd_o.sq_init   = 1'b1;
      azavg_pkg::S_SQRT:    cmd_o.sq_step   = 1'b1;
      azavg_pkg::S_LD_RD: begin
        cmd_o.mem_rd   = sts_i.load_hit;
        cmd_o.addr_sel = azavg_pkg::ADDR_LOAD;
        cmd_o.advance  = !sts_i.load_hit;
        if (!sts_i.load_hit && sts_i.img_end) phase_d = 1'b1;
      end
      azavg_pkg::S_LD_WR: begin
        cmd_o.mem_acc = 1'b1;
        cmd_o.advance = 1'b1;
        if (sts_i.img_end) phase_d = 1'b1;
      end
      azavg_pkg::S_RD_LO: begin
        cmd_o.mem_rd   = sts_i.read_hit;
        cmd_o.addr_sel = azavg_pkg::ADDR_LO;
      end
      azavg_pkg::S_DV_LO_INIT, azavg_pkg::S_DV_HI_INIT: begin
        cmd_o.dv_init = 1'b1;
        dv_cnt_d      = '0;
      end
      azavg_pkg::S_DV_LO, azavg_pkg::S_DV_HI: begin
        cmd_o.dv_step = 1'b1;
        dv_cnt_d      = dv_cnt_q + 1'b1;
      end
      azavg_pkg::S_RD_HI: begin
        cmd_o.mean_lo_cap = 1'b1;
        cmd_o.mem_rd      = 1'b1;
        cmd_o.addr_sel    = azavg_pkg::ADDR_HI;
      end
      azavg_pkg::S_MIX_A: cmd_o.mix_a = 1'b1;
      azavg_pkg::S_MIX_B: cmd_o.mix_b = 1'b1;
      azavg_pkg::S_PUSH: begin
        cmd_o.out_load = push_fire;
        cmd_o.advance  = push_fire;
        if (push_fire && sts_i.img_end) phase_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= azavg_pkg::S_CLEAR;
      phase_q     <= 1'b0;
      clr_addr_q  <= '0;
      dv_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      clr_addr_q  <= clr_addr_d;
      dv_cnt_q    <= dv_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/azavg_dp.sv
// datapath: raster position, distance, square root, bin store, mean divider, interpolation
`default_nettype none
module azavg_dp (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  azavg_pkg::cfg_t                      cfg_i,
  input  wire  signed [azavg_pkg::PIX_W-1:0]   pixel_i,
  input  azavg_pkg::dp_cmd_t                   cmd_i,
  output azavg_pkg::dp_sts_t                   sts_o,
  output logic signed [azavg_pkg::PIX_W-1:0]   out_pixel_o,
  output logic                                 last_o
);

  localparam int unsigned EW = azavg_pkg::SUM_W + azavg_pkg::CNT_W;
  localparam int unsigned RW = azavg_pkg::SQ_OUT_W + 1;

  // raster position
  logic [azavg_pkg::COL_W-1:0] col_q;
  logic [azavg_pkg::ROW_W-1:0] row_q;
  logic [azavg_pkg::DIM_W-1:0] w_eff, h_eff, nb;
  logic [azavg_pkg::COL_W:0]   col_nx;
  logic [azavg_pkg::ROW_W:0]   row_nx;
  logic                        col_wrap, img_end;

  always_comb begin
    if (cfg_i.width == '0) w_eff = azavg_pkg::DIM_W'(1);
    else if (cfg_i.width > azavg_pkg::DIM_W'(azavg_pkg::MAX_WIDTH))
      w_eff = azavg_pkg::DIM_W'(azavg_pkg::MAX_WIDTH);
    else w_eff = cfg_i.width;
    if (cfg_i.height == '0) h_eff = azavg_pkg::DIM_W'(1);
    else if (cfg_i.height > azavg_pkg::DIM_W'(azavg_pkg::MAX_HEIGHT))
      h_eff = azavg_pkg::DIM_W'(azavg_pkg::MAX_HEIGHT);
    else h_eff = cfg_i.height;
  end

  assign nb       = w_eff >> 1;
  assign col_nx   = {1'b0, col_q} + 1'b1;
  assign row_nx   = {1'b0, row_q} + 1'b1;
  assign col_wrap = azavg_pkg::DIM_W'(col_nx) >= w_eff;
  assign img_end  = col_wrap && (azavg_pkg::DIM_W'(row_nx) >= h_eff);

  // squared distance
  logic signed [azavg_pkg::DIFF_W-1:0]   dx, dy;
  logic signed [2*azavg_pkg::DIFF_W-1:0] dx2, dy2;
  logic [azavg_pkg::D2_W-1:0]            d2_q;

  assign dx  = $signed(azavg_pkg::DIFF_W'({col_q, {azavg_pkg::FRAC_BITS{1'b0}}}))
             - $signed(azavg_pkg::DIFF_W'(cfg_i.center_x));
  assign dy  = $signed(azavg_pkg::DIFF_W'({row_q, {azavg_pkg::FRAC_BITS{1'b0}}}))
             - $signed(azavg_pkg::DIFF_W'(cfg_i.center_y));
  assign dx2 = dx * dx;
  assign dy2 = dy * dy;

  // square root, two bits a step
  logic [azavg_pkg::SQ_IN_W-1:0]  sq_v_q, sq_r_q, sq_b_q, sq_t;
  logic [azavg_pkg::SQ_OUT_W-1:0] rad;
  logic [RW-1:0]                  ld_bin, rd_bin_p1;
  logic [azavg_pkg::SQ_OUT_W-1:0] rd_bin;
  logic [azavg_pkg::FRAC_BITS-1:0] frac;

  assign sq_t      = sq_r_q + sq_b_q;
  assign rad       = sq_r_q[azavg_pkg::SQ_OUT_W-1:0];
  // round half up of the distance, from the root of 4*d2
  assign ld_bin    = ({1'b0, rad} + RW'(1 << azavg_pkg::FRAC_BITS)) >> (azavg_pkg::FRAC_BITS + 1);
  assign rd_bin    = rad >> azavg_pkg::FRAC_BITS;
  assign rd_bin_p1 = {1'b0, rd_bin} + 1'b1;
  assign frac      = rad[azavg_pkg::FRAC_BITS-1:0];

  assign sts_o.sq_last  = sq_b_q[0];
  assign sts_o.load_hit = ld_bin < RW'(nb);
  assign sts_o.read_hit = rd_bin_p1 < RW'(nb);
  assign sts_o.img_end  = img_end;

  // bin store: sum and count per entry
  logic [EW-1:0]                mem_q [azavg_pkg::NBINS_MAX];
  logic [EW-1:0]                rd_q, wr_data;
  logic [azavg_pkg::BIN_AW-1:0] rd_addr, wr_addr;
  logic                         wr_en;
  logic signed [azavg_pkg::PIX_W-1:0] pix_q;
  logic [azavg_pkg::SUM_W-1:0]  rd_sum;
  logic [azavg_pkg::CNT_W-1:0]  rd_cnt;

  assign rd_sum = rd_q[EW-1:azavg_pkg::CNT_W];
  assign rd_cnt = rd_q[azavg_pkg::CNT_W-1:0];

  always_comb begin
    case (cmd_i.addr_sel)
      azavg_pkg::ADDR_LO: rd_addr = rd_bin[azavg_pkg::BIN_AW-1:0];
      azavg_pkg::ADDR_HI: rd_addr = rd_bin_p1[azavg_pkg::BIN_AW-1:0];
      default:            rd_addr = ld_bin[azavg_pkg::BIN_AW-1:0];
    endcase
  end

  assign wr_en   = cmd_i.mem_acc || cmd_i.mem_clr;
  assign wr_addr = cmd_i.mem_clr ? cmd_i.clr_addr : ld_bin[azavg_pkg::BIN_AW-1:0];
  assign wr_data = cmd_i.mem_clr ? '0 :
    {rd_sum + {{(azavg_pkg::SUM_W-azavg_pkg::PIX_W){pix_q[azavg_pkg::PIX_W-1]}}, pix_q},
     rd_cnt + 1'b1};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_rd) rd_q <= mem_q[rd_addr];
    if (wr_en) mem_q[wr_addr] <= wr_data;
  end

  // bit-serial mean divider: (|sum|*2^16 + cnt/2) / cnt
  logic [azavg_pkg::MAG_W-1:0]  dv_n_q, dv_num;
  logic [azavg_pkg::CNT_W-1:0]  dv_rem_q, dv_c_q;
  logic                         dv_neg_q, dv_zero_q;
  logic [azavg_pkg::CNT_W:0]    dv_trial, dv_diff;
  logic                         dv_ge;
  logic [azavg_pkg::SUM_W-1:0]  sum_mag;
  logic signed [azavg_pkg::MEAN_W-1:0] dv_mean, mean_lo_q;

  assign sum_mag  = rd_sum[azavg_pkg::SUM_W-1] ? (~rd_sum + 1'b1) : rd_sum;
  assign dv_num   = {sum_mag, 16'b0} + azavg_pkg::MAG_W'(rd_cnt >> 1);
  assign dv_trial = {dv_rem_q, dv_n_q[azavg_pkg::MAG_W-1]};
  assign dv_ge    = dv_trial >= {1'b0, dv_c_q};
  assign dv_diff  = dv_trial - {1'b0, dv_c_q};

  always_comb begin
    if (dv_zero_q) dv_mean = '0;
    else if (dv_neg_q) dv_mean = -$signed({1'b0, dv_n_q});
    else dv_mean = $signed({1'b0, dv_n_q});
  end

  // interpolation and rounding
  logic [azavg_pkg::FRAC_BITS:0]      w_lo;
  logic signed [azavg_pkg::WGT_W-1:0] w_lo_s, w_hi_s;
  logic signed [azavg_pkg::ACC_W-1:0] prod_a, prod_b, acc_q;
  logic [azavg_pkg::ACC_W-1:0]        acc_mag, acc_q_rnd;
  logic                               acc_neg;
  logic signed [azavg_pkg::PIX_W-1:0] sat;

  assign w_lo   = (azavg_pkg::FRAC_BITS+1)'(1 << azavg_pkg::FRAC_BITS) - {1'b0, frac};
  assign w_lo_s = $signed({1'b0, w_lo});
  assign w_hi_s = $signed({2'b00, frac});
  assign prod_a = mean_lo_q * w_lo_s;
  assign prod_b = dv_mean * w_hi_s;

  assign acc_neg   = acc_q[azavg_pkg::ACC_W-1];
  assign acc_mag   = acc_neg ? (~acc_q + 1'b1) : acc_q;
  assign acc_q_rnd = (acc_mag + (azavg_pkg::ACC_W'(1) << (azavg_pkg::RND_SH - 1)))
                     >> azavg_pkg::RND_SH;

  always_comb begin
    if (!acc_neg) begin
      if (acc_q_rnd > azavg_pkg::ACC_W'(32767)) sat = 16'sh7FFF;
      else sat = $signed(acc_q_rnd[azavg_pkg::PIX_W-1:0]);
    end else begin
      if (acc_q_rnd > azavg_pkg::ACC_W'(32768)) sat = 16'sh8000;
      else sat = $signed(~acc_q_rnd[azavg_pkg::PIX_W-1:0] + 1'b1);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_pixel) pix_q <= pixel_i;
    if (cmd_i.mul_x) d2_q <= dx2[azavg_pkg::D2_W-1:0];
    if (cmd_i.mul_y) d2_q <= d2_q + dy2[azavg_pkg::D2_W-1:0];
    if (cmd_i.sq_init) begin
      sq_v_q <= cmd_i.sq_quad ? azavg_pkg::SQ_IN_W'({d2_q, 2'b00}) : azavg_pkg::SQ_IN_W'(d2_q);
      sq_r_q <= '0;
      sq_b_q <= azavg_pkg::SQ_IN_W'(1) << (azavg_pkg::SQ_IN_W - 2);
    end else if (cmd_i.sq_step) begin
      if (sq_v_q >= sq_t) begin
        sq_v_q <= sq_v_q - sq_t;
        sq_r_q <= (sq_r_q >> 1) + sq_b_q;
      end else begin
        sq_r_q <= sq_r_q >> 1;
      end
      sq_b_q <= sq_b_q >> 2;
    end
    if (cmd_i.dv_init) begin
      dv_n_q    <= dv_num;
      dv_rem_q  <= '0;
      dv_c_q    <= rd_cnt;
      dv_neg_q  <= rd_sum[azavg_pkg::SUM_W-1];
      dv_zero_q <= (rd_cnt == '0);
    end else if (cmd_i.dv_step) begin
      dv_rem_q <= dv_ge ? dv_diff[azavg_pkg::CNT_W-1:0] : dv_trial[azavg_pkg::CNT_W-1:0];
      dv_n_q   <= {dv_n_q[azavg_pkg::MAG_W-2:0], dv_ge};
    end
    if (cmd_i.mean_lo_cap) mean_lo_q <= dv_mean;
    if (cmd_i.mix_a) acc_q <= prod_a;
    if (cmd_i.mix_b) acc_q <= acc_q + prod_b;
    if (cmd_i.out_load) begin
      out_pixel_o <= sts_o.read_hit ? sat : '0;
      last_o      <= img_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.advance) begin
      if (col_wrap) begin
        col_q <= '0;
        row_q <= img_end ? '0 : row_nx[azavg_pkg::ROW_W-1:0];
      end else begin
        col_q <= col_nx[azavg_pkg::COL_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/azimuthal_average_reconstruct.sv
// top level of the azimuthal average reconstruction block
//
//  channel  direction  handshake                  payload
//  in       input      in_valid_i / in_ready_o    command_i, pixel_i
//  out      output     out_valid_o / out_ready_i  out_pixel_o, last_o
//  config   input      psel/penable/pwrite/pready paddr, pwdata, prdata
//
// a load beat: two multiplies, 16 root steps, a read and a write of the bin store when in range
// a read beat with its bins in range runs the 52-step bit-serial mean divider twice
// a beat in the wrong phase is taken and dropped
// after reset and after the last output beat a pass over all 512 entries clears the bin store
// a finished result waits in the output register; the next beat is taken meanwhile
`default_nettype none
module azimuthal_average_reconstruct (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  wire                                 command_i,
  input  wire  signed [azavg_pkg::PIX_W-1:0]  pixel_i,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic signed [azavg_pkg::PIX_W-1:0]  out_pixel_o,
  output logic                                last_o,
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire  [azavg_pkg::PADDR_W-1:0]       paddr,
  input  wire  [azavg_pkg::PDATA_W-1:0]       pwdata,
  output logic [azavg_pkg::PDATA_W-1:0]       prdata,
  output logic                                pready
);

  azavg_pkg::cfg_t    cfg;
  azavg_pkg::dp_cmd_t cmd;
  azavg_pkg::dp_sts_t sts;

  azavg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  azavg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .command_i   (command_i),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  azavg_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .pixel_i     (pixel_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_pixel_o (out_pixel_o),
    .last_o      (last_o)
  );

endmodule
`default_nettype wire

### hw/rtl/azavg_checker.sv
// port-level checks of the azimuthal average reconstruction block
`default_nettype none
module azavg_props (
  input wire                                clk_i,
  input wire                                rst_ni,
  input wire                                in_ready_o,
  input wire                                out_valid_o,
  input wire                                out_ready_i,
  input wire signed [azavg_pkg::PIX_W-1:0]  out_pixel_o,
  input wire                                last_o
);

  // a stalled output beat keeps its valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  // a stalled output beat keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_pixel_o) && $stable(last_o))
    else $error("output payload changed while stalled");

  // the store is being cleared after reset, so no input is taken
  a_reset_busy: assert property (@(posedge clk_i) !rst_ni |=> !in_ready_o)
    else $error("input ready right after reset");

  // a new result comes only from a busy block
  a_out_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared while idle");

endmodule

bind azimuthal_average_reconstruct azavg_props u_checker (.*);
`default_nettype wire

### test/azavg_checker.sv
// beat monitor, radial profile predictor and result comparator for the azimuthal average block
`timescale 1ns / 100ps
module azavg_checker (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  input  wire                in_ready_i,
  input  wire                command_i,
  input  wire  signed [15:0] pixel_i,
  input  wire                out_valid_i,
  input  wire                out_ready_i,
  input  wire  signed [15:0] out_pixel_i,
  input  wire                last_i,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire                pready,
  input  wire  [3:0]         paddr,
  input  wire  [31:0]        pwdata,
  output int                 fail_count,
  output int                 pending,
  output logic               reading
);

  typedef struct packed {
    logic signed [15:0] pix;
    logic               last;
  } profile_px_t;

  logic [35:0]  bin_sum [azavg_pkg::NBINS_MAX];
  logic [20:0]  bin_cnt [azavg_pkg::NBINS_MAX];
  logic [10:0]  cfg_width, cfg_height;
  logic [13:0]  cfg_cx, cfg_cy;
  int unsigned  col, row;
  profile_px_t  profile_q [$];

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, t;
    r = 0;
    for (int b = 24; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic int unsigned eff_w();
    if (cfg_width > azavg_pkg::MAX_WIDTH) return azavg_pkg::MAX_WIDTH;
    if (cfg_width < 1) return 1;
    return cfg_width;
  endfunction

  function automatic int unsigned eff_h();
    if (cfg_height > azavg_pkg::MAX_HEIGHT) return azavg_pkg::MAX_HEIGHT;
    if (cfg_height < 1) return 1;
    return cfg_height;
  endfunction

  function automatic longint bin_mean(int unsigned b);
    longint s;
    if (bin_cnt[b] == 0) return 0;
    s = longint'($signed(bin_sum[b]));
    return round_div(s * 65536, longint'(bin_cnt[b]));
  endfunction

  function automatic longint unsigned radius_sq();
    longint dx, dy;
    dx = longint'(col) * 16 - longint'(cfg_cx);
    dy = longint'(row) * 16 - longint'(cfg_cy);
    return dx * dx + dy * dy;
  endfunction

  // returns 1 when the raster scan wraps past the last row
  function automatic bit step_position();
    col++;
    if (col >= eff_w()) begin
      col = 0;
      row++;
      if (row >= eff_h()) begin
        row = 0;
        return 1;
      end
    end
    return 0;
  endfunction

  task automatic clear_bins();
    for (int b = 0; b < azavg_pkg::NBINS_MAX; b++) begin
      bin_sum[b] = '0;
      bin_cnt[b] = '0;
    end
  endtask

  task automatic predict_beat(azavg_pkg::cmd_e cmd, logic signed [15:0] pix);
    longint unsigned d2, r, bin, frac;
    int unsigned nb;
    longint val, num;
    bit done;
    profile_px_t px;
    nb = eff_w() / 2;
    d2 = radius_sq();
    if (cmd == azavg_pkg::CMD_LOAD) begin
      if (reading) return;
      bin = (root_floor(4 * d2) + 16) >> 5;
      if (bin < nb) begin
        bin_sum[bin] = bin_sum[bin] + {{20{pix[15]}}, pix};
        bin_cnt[bin] = bin_cnt[bin] + 21'd1;
      end
      if (step_position()) reading = 1'b1;
    end else begin
      if (!reading) return;
      r = root_floor(d2);
      bin = r >> 4;
      frac = r & 15;
      val = 0;
      if (bin + 1 < nb) begin
        num = (16 - longint'(frac)) * bin_mean(32'(bin))
            + longint'(frac) * bin_mean(32'(bin + 1));
        val = round_div(num, 64'd16 << 16);
        if (val > 32767) val = 32767;
        if (val < -32768) val = -32768;
      end
      done = step_position();
      px.pix = val[15:0];
      px.last = done;
      profile_q.push_back(px);
      if (done) begin
        clear_bins();
        reading = 1'b0;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    profile_px_t want;
    if (!rst_ni) begin
      clear_bins();
      cfg_width = 11'd512;
      cfg_height = 11'd512;
      cfg_cx = 14'd4096;
      cfg_cy = 14'd3688;
      col = 0;
      row = 0;
      reading = 1'b0;
      fail_count = 0;
      profile_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (azavg_pkg::reg_idx_e'(paddr[3:2]))
          azavg_pkg::REG_WIDTH:    cfg_width = pwdata[10:0];
          azavg_pkg::REG_HEIGHT:   cfg_height = pwdata[10:0];
          azavg_pkg::REG_CENTER_X: cfg_cx = pwdata[13:0];
          azavg_pkg::REG_CENTER_Y: cfg_cy = pwdata[13:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (profile_q.size() == 0) begin
          $error("output beat with no result expected: out_pixel=%0d last=%0b",
                 out_pixel_i, last_i);
          fail_count++;
        end else begin
          want = profile_q.pop_front();
          if (out_pixel_i !== want.pix) begin
            $error("out_pixel: expected %0d, got %0d", want.pix, out_pixel_i);
            fail_count++;
          end
          if (last_i !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last_i);
            fail_count++;
          end
        end
      end
      if (in_valid_i && in_ready_i) predict_beat(azavg_pkg::cmd_e'(command_i), pixel_i);
    end
    pending = profile_q.size();
  end

endmodule

### test/tb.sv
// stimulus and verdict for the azimuthal average reconstruction block
`timescale 1ns / 100ps
module tb;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int HOLD_CYCLES = 3000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               command_i = 1'b0;
  logic signed [15:0] pixel_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [15:0] out_pixel_o;
  logic               last_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  int   fail_count, pending;
  logic reading;
  int   cycles = 0;
  int   n_loads = 0, n_reads = 0, n_stray = 0, n_images = 0;
  int   out_beats = 0;
  bit   held = 0;
  logic signed [15:0] pix_list [$];

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  azimuthal_average_reconstruct DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .command_i, .pixel_i,
    .out_valid_o, .out_ready_i, .out_pixel_o, .last_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  azavg_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .command_i, .pixel_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_pixel_i(out_pixel_o), .last_i(last_o),
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fail_count, .pending, .reading
  );

  // no random input gaps and no random receiver stalls in this window
  function automatic bit calm();
    return cycles > 30000 && cycles < 80000;
  endfunction

  always @(posedge clk_i) begin
    cycles++;
    if (out_valid_o && out_ready_i) out_beats++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off after 40 output beats
  always @(negedge clk_i) begin
    if (!held && out_beats >= 40) begin
      held = 1;
      out_ready_i <= 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk_i);
    end
    out_ready_i <= calm() || ($urandom_range(0, 99) >= 15);
  end

  function automatic logic signed [15:0] pick_pixel();
    if (pix_list.size() > 0) return pix_list.pop_front();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return -16'sh8000;
      2: return 16'sd0;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_beat(azavg_pkg::cmd_e cmd, logic signed [15:0] pix);
    if (!calm() && $urandom_range(0, 99) < 15) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    pixel_i <= pix;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // let the block drain and finish its clearing pass
  task automatic settle(int extra);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic reg_write(azavg_pkg::reg_idx_e idx, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_geometry(int w, int h, int cx, int cy);
    reg_write(azavg_pkg::REG_WIDTH, w);
    reg_write(azavg_pkg::REG_HEIGHT, h);
    reg_write(azavg_pkg::REG_CENTER_X, cx);
    reg_write(azavg_pkg::REG_CENTER_Y, cy);
  endtask

  // loads until the scan wraps, with occasional stray read beats
  task automatic load_rest();
    while (!reading) begin
      if ($urandom_range(0, 99) < 3) begin
        send_beat(azavg_pkg::CMD_READ, 16'($urandom()));
        n_stray++;
      end
      send_beat(azavg_pkg::CMD_LOAD, pick_pixel());
      n_loads++;
    end
  endtask

  task automatic read_out(bit drain_pause);
    int k;
    k = 0;
    while (reading) begin
      if ($urandom_range(0, 99) < 3) begin
        send_beat(azavg_pkg::CMD_LOAD, 16'($urandom()));
        n_stray++;
      end
      if (drain_pause && k == 5) settle(0);
      send_beat(azavg_pkg::CMD_READ, 16'($urandom()));
      n_reads++;
      k++;
    end
    n_images++;
  endtask

  task automatic run_image(int w, int h, int cx, int cy, bit drain_pause);
    settle(600);
    set_geometry(w, h, cx, cy);
    load_rest();
    read_out(drain_pause);
  endtask

  initial begin
    int w, h, cx, cy;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // small image from a fixed pixel list that includes both extremes, stray beats in both phases
    pix_list = '{16'sh7fff, -16'sh8000, 16'sd0, -16'sd1, 16'sd1, -16'sd2, 16'sh5555, -16'sh5556};
    settle(600);
    set_geometry(4, 2, 24, 8);
    send_beat(azavg_pkg::CMD_READ, 16'sd0);
    n_stray++;
    load_rest();
    send_beat(azavg_pkg::CMD_READ, 16'sd0);
    n_reads++;
    send_beat(azavg_pkg::CMD_LOAD, 16'sh7fff);
    n_stray++;
    read_out(0);

    // zero sizes clamp to one pixel, no bins at all
    run_image(0, 0, 0, 0, 0);

    // maximum sizes and far centre, shrunk mid-scan
    settle(600);
    set_geometry(2047, 2047, 16383, 16383);
    repeat (3) begin
      send_beat(azavg_pkg::CMD_LOAD, pick_pixel());
      n_loads++;
    end
    settle(100);
    reg_write(azavg_pkg::REG_WIDTH, 2);
    reg_write(azavg_pkg::REG_HEIGHT, 2);
    reg_write(azavg_pkg::REG_CENTER_X, 0);
    load_rest();
    read_out(0);

    while (n_loads + n_reads < 1550) begin
      w = $urandom_range(2, 16);
      h = $urandom_range(1, 6);
      if ($urandom_range(0, 4) == 0) begin
        cx = $urandom_range(0, 16383);
        cy = $urandom_range(0, 16383);
      end else begin
        cx = $urandom_range(0, w * 16);
        cy = $urandom_range(0, h * 16);
      end
      if ($urandom_range(0, 19) == 0) w = $urandom_range(0, 1);
      run_image(w, h, cx, cy, n_images == 6);
    end

    settle(600);
    $display("tb: %0d images, %0d loads, %0d reads, %0d out-of-phase beats",
             n_images, n_loads, n_reads, n_stray);
    $display("tb: sizes from clamped zero to 2047, centres over the full range, mid-scan shrink");
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/azavg_pkg.sv
hw/rtl/azavg_regs.sv
hw/rtl/azavg_ctrl.sv
hw/rtl/azavg_dp.sv
hw/rtl/azimuthal_average_reconstruct.sv
hw/rtl/azavg_checker.sv
test/azavg_checker.sv
test/tb.sv
